// ===== rtl/core/rss_pkg.sv =====
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants and the back-end state type for the running sample
// statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rss_pkg;

   localparam int SampleBitsDefault = 24;
   localparam int CountBitsDefault  = 16;

   // fixed port widths
   localparam int CountPortBits  = 16;
   localparam int SamplePortBits = 24;
   localparam int VarPortBits    = 48;

   localparam logic CmdCollect = 1'b0;
   localparam logic CmdClear   = 1'b1;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_MEAN,
      BE_MUL,
      BE_TDIV,
      BE_VDIV,
      BE_DONE
   } be_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/rss_front.sv =====
// ----------------------------------------------------------------------------
// rss_front
// Accumulator front end: takes one word a cycle while the queue has room;
// updates count, sum, sum of squares, min and max; pushes the new state.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_front #(
   parameter int SAMPLE_BITS = rss_pkg::SampleBitsDefault,
   parameter int COUNT_BITS  = rss_pkg::CountBitsDefault,
   parameter int SNAP_BITS   = COUNT_BITS + (SAMPLE_BITS + COUNT_BITS)
                               + (2 * SAMPLE_BITS + COUNT_BITS - 1) + 2 * SAMPLE_BITS + 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire logic                                 command,
   input  wire logic [rss_pkg::SamplePortBits-1:0]   sample,
   input  wire logic                                 q_full,
   output logic                                      q_push,
   output logic [SNAP_BITS-1:0]                      q_data
);

   localparam int SW = SAMPLE_BITS + COUNT_BITS;
   localparam int QW = 2 * SAMPLE_BITS + COUNT_BITS - 1;

   logic [COUNT_BITS-1:0]         n_ff, n_in;
   logic signed [SW-1:0]          sum_ff, sum_in;
   logic [QW-1:0]                 sq_ff, sq_in;
   logic signed [SAMPLE_BITS-1:0] mn_ff, mn_in, mx_ff, mx_in;
   logic                          ovf_ff, ovf_in;

   logic signed [SAMPLE_BITS-1:0] v;
   logic [SAMPLE_BITS-1:0]        mag;
   logic [2*SAMPLE_BITS-1:0]      sqr;
   logic                          accept;

   assign accept = push && !q_full;
   assign v      = signed'(sample[SAMPLE_BITS-1:0]);
   assign mag    = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
   assign sqr    = mag * mag;

   always_comb begin
      n_in   = n_ff;
      sum_in = sum_ff;
      sq_in  = sq_ff;
      mn_in  = mn_ff;
      mx_in  = mx_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (command == rss_pkg::CmdClear) begin
            n_in   = '0;
            sum_in = '0;
            sq_in  = '0;
            mn_in  = '0;
            mx_in  = '0;
            ovf_in = 1'b0;
         end else if (n_ff == {COUNT_BITS{1'b1}}) begin
            // drop the sample, keep the accumulators
            ovf_in = 1'b1;
         end else begin
            n_in   = n_ff + COUNT_BITS'(1);
            sum_in = sum_ff + SW'(v);
            sq_in  = sq_ff + QW'(sqr);
            if (n_ff == '0) begin
               mn_in = v;
               mx_in = v;
            end else begin
               if (v < mn_ff) mn_in = v;
               if (v > mx_ff) mx_in = v;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff   <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
         mn_ff  <= '0;
         mx_ff  <= '0;
         ovf_ff <= 1'b0;
      end else begin
         n_ff   <= n_in;
         sum_ff <= sum_in;
         sq_ff  <= sq_in;
         mn_ff  <= mn_in;
         mx_ff  <= mx_in;
         ovf_ff <= ovf_in;
      end
   end

   assign q_push = accept;
   assign q_data = {n_in, sum_in, sq_in, mn_in, mx_in, ovf_in};

endmodule

`default_nettype wire

// ===== rtl/core/rss_queue.sv =====
// ----------------------------------------------------------------------------
// rss_queue
// Two-entry snapshot queue between the accumulator front and the divide back.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      pop_data
);

   logic [WIDTH-1:0] mem [2];
   logic             wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = cnt_ff == 2'd2;
   assign valid    = cnt_ff != 2'd0;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = mem[rp_ff];

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (do_push) mem[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/rss_back.sv =====
// ----------------------------------------------------------------------------
// rss_back
// Result back end: one shared restoring divider and a shift-add squarer work
// out mean and variance bit by bit, then fill the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rss_back #(
   parameter int SAMPLE_BITS = rss_pkg::SampleBitsDefault,
   parameter int COUNT_BITS  = rss_pkg::CountBitsDefault,
   parameter int SNAP_BITS   = COUNT_BITS + (SAMPLE_BITS + COUNT_BITS)
                               + (2 * SAMPLE_BITS + COUNT_BITS - 1) + 2 * SAMPLE_BITS + 1
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      q_valid,
   input  wire logic [SNAP_BITS-1:0]                      q_data,
   output logic                                           q_pop,
   output logic                                           rsp_empty,
   input  wire logic                                      rsp_pop,
   output logic [rss_pkg::CountPortBits-1:0]              rsp_sample_count,
   output logic signed [rss_pkg::SamplePortBits-1:0]      rsp_mean_value,
   output logic [rss_pkg::VarPortBits-1:0]                rsp_variance_value,
   output logic signed [rss_pkg::SamplePortBits-1:0]      rsp_minimum_value,
   output logic signed [rss_pkg::SamplePortBits-1:0]      rsp_maximum_value,
   output logic                                           rsp_count_overflow
);

   localparam int S  = SAMPLE_BITS;
   localparam int C  = COUNT_BITS;
   localparam int SW = S + C;
   localparam int QW = 2 * S + C - 1;
   localparam int PW = 2 * SW;
   localparam int VB = rss_pkg::VarPortBits;
   localparam int XW = (QW > VB) ? QW : VB;
   localparam int KW = $clog2(PW + 1);

   rss_pkg::be_state_type st_ff, st_in;

   logic [KW-1:0]         cnt_ff, cnt_in;
   logic [PW-1:0]         dq_ff, dq_in;
   logic [C-1:0]          rem_ff, rem_in;
   logic [C-1:0]          dvs_ff, dvs_in;
   logic [PW-1:0]         prod_ff, prod_in;
   logic [SW-1:0]         mpl_ff, mpl_in;
   logic [SW-1:0]         mag_ff, mag_in;
   logic [C-1:0]          n_ff, n_in;
   logic signed [SW-1:0]  sum_ff, sum_in;
   logic [QW-1:0]         sq_ff, sq_in;
   logic [S-1:0]          mn_ff, mn_in, mx_ff, mx_in;
   logic                  ovf_ff, ovf_in;
   logic [S-1:0]          mean_ff, mean_in;
   logic [VB-1:0]         var_ff, var_in;

   logic                  outv_ff, outv_in;
   logic [C-1:0]          o_n_ff, o_n_in;
   logic [S-1:0]          o_mean_ff, o_mean_in, o_mn_ff, o_mn_in, o_mx_ff, o_mx_in;
   logic [VB-1:0]         o_var_ff, o_var_in;
   logic                  o_ovf_ff, o_ovf_in;

   // snapshot fields
   logic [C-1:0]          s_n;
   logic signed [SW-1:0]  s_sum;
   logic [QW-1:0]         s_sq;
   logic [S-1:0]          s_mn, s_mx;
   logic                  s_ovf;

   // divider step
   logic [C:0]            shf, rem_nx;
   logic                  ge;
   logic [PW-1:0]         dq_nx;
   logic [PW-1:0]         prod_nx;
   logic [SW-1:0]         quot_sw, mean_full;
   logic [XW-1:0]         qx;
   logic                  last;
   logic                  out_free;

   assign {s_n, s_sum, s_sq, s_mn, s_mx, s_ovf} = q_data;

   assign shf     = {rem_ff, dq_ff[PW-1]};
   assign ge      = shf >= {1'b0, dvs_ff};
   assign rem_nx  = ge ? shf - {1'b0, dvs_ff} : shf;
   assign dq_nx   = {dq_ff[PW-2:0], ge};
   assign prod_nx = {prod_ff[PW-2:0], 1'b0} + (mpl_ff[SW-1] ? PW'(mag_ff) : '0);
   assign quot_sw = dq_nx[SW-1:0];
   assign mean_full = sum_ff[SW-1] ? SW'(-quot_sw) : quot_sw;
   assign qx      = XW'(dq_nx[QW-1:0]);
   assign last    = cnt_ff == KW'(1);
   assign out_free = !outv_ff || rsp_pop;

   always_comb begin
      st_in     = st_ff;
      cnt_in    = cnt_ff;
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      prod_in   = prod_ff;
      mpl_in    = mpl_ff;
      mag_in    = mag_ff;
      n_in      = n_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      mn_in     = mn_ff;
      mx_in     = mx_ff;
      ovf_in    = ovf_ff;
      mean_in   = mean_ff;
      var_in    = var_ff;
      outv_in   = outv_ff && !rsp_pop;
      o_n_in    = o_n_ff;
      o_mean_in = o_mean_ff;
      o_mn_in   = o_mn_ff;
      o_mx_in   = o_mx_ff;
      o_var_in  = o_var_ff;
      o_ovf_in  = o_ovf_ff;
      q_pop     = 1'b0;

      unique case (st_ff)
         rss_pkg::BE_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               n_in   = s_n;
               sum_in = s_sum;
               sq_in  = s_sq;
               mn_in  = s_mn;
               mx_in  = s_mx;
               ovf_in = s_ovf;
               mag_in = s_sum[SW-1] ? SW'(-s_sum) : SW'(s_sum);
               dq_in  = {mag_in, {(PW-SW){1'b0}}};
               rem_in = '0;
               dvs_in = s_n;
               cnt_in = KW'(SW);
               st_in  = rss_pkg::BE_MEAN;
            end
         end
         rss_pkg::BE_MEAN: begin
            dq_in  = dq_nx;
            rem_in = rem_nx[C-1:0];
            cnt_in = cnt_ff - KW'(1);
            if (last) begin
               mean_in = (n_ff == '0) ? '0 : mean_full[S-1:0];
               prod_in = '0;
               mpl_in  = mag_ff;
               cnt_in  = KW'(SW);
               st_in   = rss_pkg::BE_MUL;
            end
         end
         rss_pkg::BE_MUL: begin
            prod_in = prod_nx;
            mpl_in  = {mpl_ff[SW-2:0], 1'b0};
            cnt_in  = cnt_ff - KW'(1);
            if (last) begin
               dq_in  = prod_nx;
               rem_in = '0;
               dvs_in = n_ff;
               cnt_in = KW'(PW);
               st_in  = rss_pkg::BE_TDIV;
            end
         end
         rss_pkg::BE_TDIV: begin
            dq_in  = dq_nx;
            rem_in = rem_nx[C-1:0];
            cnt_in = cnt_ff - KW'(1);
            if (last) begin
               st_in = rss_pkg::BE_VDIV;
               if (n_ff <= C'(1) || sq_ff <= dq_nx[QW-1:0]) begin
                  var_in = '0;
                  st_in  = rss_pkg::BE_DONE;
               end else begin
                  cnt_in = KW'(QW);
                  rem_in = '0;
                  dvs_in = n_ff - C'(1);
                  dq_in  = {sq_ff - dq_nx[QW-1:0], {(PW-QW){1'b0}}};
               end
            end
         end
         rss_pkg::BE_VDIV: begin
            dq_in  = dq_nx;
            rem_in = rem_nx[C-1:0];
            cnt_in = cnt_ff - KW'(1);
            if (last) begin
               // saturate to the port width
               var_in = (qx > XW'({VB{1'b1}})) ? {VB{1'b1}} : qx[VB-1:0];
               st_in  = rss_pkg::BE_DONE;
            end
         end
         rss_pkg::BE_DONE: begin
            if (out_free) begin
               outv_in   = 1'b1;
               o_n_in    = n_ff;
               o_mean_in = mean_ff;
               o_mn_in   = mn_ff;
               o_mx_in   = mx_ff;
               o_var_in  = var_ff;
               o_ovf_in  = ovf_ff;
               st_in     = rss_pkg::BE_IDLE;
            end
         end
         default: st_in = rss_pkg::BE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= rss_pkg::BE_IDLE;
         cnt_ff  <= '0;
         outv_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         outv_ff <= outv_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff     <= dq_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      prod_ff   <= prod_in;
      mpl_ff    <= mpl_in;
      mag_ff    <= mag_in;
      n_ff      <= n_in;
      sum_ff    <= sum_in;
      sq_ff     <= sq_in;
      mn_ff     <= mn_in;
      mx_ff     <= mx_in;
      ovf_ff    <= ovf_in;
      mean_ff   <= mean_in;
      var_ff    <= var_in;
      o_n_ff    <= o_n_in;
      o_mean_ff <= o_mean_in;
      o_mn_ff   <= o_mn_in;
      o_mx_ff   <= o_mx_in;
      o_var_ff  <= o_var_in;
      o_ovf_ff  <= o_ovf_in;
   end

   assign rsp_empty          = !outv_ff;
   assign rsp_sample_count   = rss_pkg::CountPortBits'(o_n_ff);
   assign rsp_mean_value     = rss_pkg::SamplePortBits'(signed'(o_mean_ff));
   assign rsp_variance_value = o_var_ff;
   assign rsp_minimum_value  = rss_pkg::SamplePortBits'(signed'(o_mn_ff));
   assign rsp_maximum_value  = rss_pkg::SamplePortBits'(signed'(o_mx_ff));
   assign rsp_count_overflow = o_ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/core/running_sample_statistics_top.sv =====
// ----------------------------------------------------------------------------
// running_sample_statistics_top
// Running count, mean, variance, minimum and maximum of signed samples.
//
//   channel | direction | handshake        | words
//   req_    | in        | req_push/full    | command, sample
//   rsp_    | out       | rsp_pop/empty    | count, mean, variance, min, max, ovf
//
// The front end takes one word per cycle while its two-entry queue has room.
// The back end takes one snapshot from the queue at a time and works out
// mean and variance with the shared bit-serial divider and squarer, skipping
// the variance divide when the variance is known to be zero.
// Synchronous reset clears the statistics and empties the queue and results.
// The front stalls when the queue is full; the back holds a finished word in
// the result register until popped.
// ----------------------------------------------------------------------------
`default_nettype none

module running_sample_statistics_top #(
   parameter int SAMPLE_BITS = rss_pkg::SampleBitsDefault,
   parameter int COUNT_BITS  = rss_pkg::CountBitsDefault
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_push,
   output logic                                        req_full,
   input  wire logic                                   req_command,
   input  wire logic signed [rss_pkg::SamplePortBits-1:0] req_sample,
   output logic                                        rsp_empty,
   input  wire logic                                   rsp_pop,
   output logic [rss_pkg::CountPortBits-1:0]           rsp_sample_count,
   output logic signed [rss_pkg::SamplePortBits-1:0]   rsp_mean_value,
   output logic [rss_pkg::VarPortBits-1:0]             rsp_variance_value,
   output logic signed [rss_pkg::SamplePortBits-1:0]   rsp_minimum_value,
   output logic signed [rss_pkg::SamplePortBits-1:0]   rsp_maximum_value,
   output logic                                        rsp_count_overflow
);

   localparam int SNAP_BITS = COUNT_BITS + (SAMPLE_BITS + COUNT_BITS)
                              + (2 * SAMPLE_BITS + COUNT_BITS - 1) + 2 * SAMPLE_BITS + 1;

   logic                 q_push, q_full, q_pop, q_valid;
   logic [SNAP_BITS-1:0] q_wdata, q_rdata;

   rss_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .SNAP_BITS   (SNAP_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .command (req_command),
      .sample  (req_sample),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_wdata)
   );

   rss_queue #(
      .WIDTH (SNAP_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_rdata)
   );

   rss_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS),
      .SNAP_BITS   (SNAP_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_rdata),
      .q_pop              (q_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_mean_value     (rsp_mean_value),
      .rsp_variance_value (rsp_variance_value),
      .rsp_minimum_value  (rsp_minimum_value),
      .rsp_maximum_value  (rsp_maximum_value),
      .rsp_count_overflow (rsp_count_overflow)
   );

   assign req_full = q_full;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// Running sample statistics testbench
// Pushes directed and random sample/clear words; random phases idle the
// sender, stall the receiver, both or neither. A scoreboard keeps its own
// running statistics, predicts every result word and compares each field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SmpBits  = rss_pkg::SampleBitsDefault;
   localparam int CntBits  = rss_pkg::CountBitsDefault;
   localparam int StallLimit = 20000;
   localparam int DrainCycles = 400;

   typedef struct {
      logic [rss_pkg::CountPortBits-1:0]         count;
      logic signed [rss_pkg::SamplePortBits-1:0] mean;
      logic [rss_pkg::VarPortBits-1:0]           variance;
      logic signed [rss_pkg::SamplePortBits-1:0] minimum;
      logic signed [rss_pkg::SamplePortBits-1:0] maximum;
      logic                                      overflow;
   } stats_word_type;

   class stats_scoreboard;
      bit [15:0]                       total;
      longint                          sum;
      bit [63:0]                       sq_sum;
      logic signed [SmpBits-1:0]       lo, hi;
      bit                              ovf;
      stats_word_type                  expected_words[$];
      int                              errors;
      int                              checked;

      function void clear_stats();
         total = 0;
         sum = 0;
         sq_sum = 0;
         lo = 0;
         hi = 0;
         ovf = 0;
      endfunction

      function void note_input(logic cmd, logic signed [rss_pkg::SamplePortBits-1:0] smp);
         stats_word_type w;
         longint v;
         bit [127:0] mag, sq_over_n, var_full;
         if (cmd == rss_pkg::CmdClear) begin
            clear_stats();
         end else if (total >= (1 << CntBits) - 1) begin
            ovf = 1;
         end else begin
            v = longint'(smp);
            total++;
            sum += v;
            sq_sum += 64'(v * v);
            if (total == 1) begin
               lo = smp;
               hi = smp;
            end else if (smp < lo) begin
               lo = smp;
            end else if (smp > hi) begin
               hi = smp;
            end
         end
         w.count = total;
         w.mean = (total == 0) ? '0 :
                  rss_pkg::SamplePortBits'(sum / longint'(total));
         w.variance = '0;
         if (total > 1) begin
            mag = (sum < 0) ? 128'(-sum) : 128'(sum);
            sq_over_n = (mag * mag) / total;
            if (128'(sq_sum) > sq_over_n) begin
               var_full = (128'(sq_sum) - sq_over_n) / (total - 1);
               w.variance = (var_full > 128'({rss_pkg::VarPortBits{1'b1}})) ?
                            {rss_pkg::VarPortBits{1'b1}} :
                            rss_pkg::VarPortBits'(var_full);
            end
         end
         w.minimum = lo;
         w.maximum = hi;
         w.overflow = ovf;
         expected_words.push_back(w);
      endfunction

      function void check_result(stats_word_type got);
         stats_word_type exp_w;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result word, count %0d", $time, got.count);
            errors++;
            return;
         end
         exp_w = expected_words.pop_front();
         checked++;
         if (got.count !== exp_w.count) begin
            $display("%0t: count exp %0d got %0d", $time, exp_w.count, got.count);
            errors++;
         end
         if (got.mean !== exp_w.mean) begin
            $display("%0t: mean exp %0d got %0d", $time, exp_w.mean, got.mean);
            errors++;
         end
         if (got.variance !== exp_w.variance) begin
            $display("%0t: variance exp %0d got %0d", $time, exp_w.variance,
                     got.variance);
            errors++;
         end
         if (got.minimum !== exp_w.minimum) begin
            $display("%0t: min exp %0d got %0d", $time, exp_w.minimum, got.minimum);
            errors++;
         end
         if (got.maximum !== exp_w.maximum) begin
            $display("%0t: max exp %0d got %0d", $time, exp_w.maximum, got.maximum);
            errors++;
         end
         if (got.overflow !== exp_w.overflow) begin
            $display("%0t: overflow exp %0b got %0b", $time, exp_w.overflow,
                     got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic                                       clock = 0;
   logic                                       reset = 1;
   logic                                       req_push = 0;
   logic                                       req_full;
   logic                                       req_command = rss_pkg::CmdCollect;
   logic signed [rss_pkg::SamplePortBits-1:0]  req_sample = '0;
   logic                                       rsp_empty;
   logic                                       rsp_pop = 0;
   logic [rss_pkg::CountPortBits-1:0]          rsp_sample_count;
   logic signed [rss_pkg::SamplePortBits-1:0]  rsp_mean_value;
   logic [rss_pkg::VarPortBits-1:0]            rsp_variance_value;
   logic signed [rss_pkg::SamplePortBits-1:0]  rsp_minimum_value;
   logic signed [rss_pkg::SamplePortBits-1:0]  rsp_maximum_value;
   logic                                       rsp_count_overflow;

   stats_scoreboard sb = new();
   int send_idle_pct = 0;
   int pop_stall_pct = 0;
   int quiet_cycles = 0;
   int samples_sent = 0;
   int clears_sent = 0;

   running_sample_statistics_top #(
      .SAMPLE_BITS(SmpBits),
      .COUNT_BITS (CntBits)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_command       (req_command),
      .req_sample        (req_sample),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_mean_value    (rsp_mean_value),
      .rsp_variance_value(rsp_variance_value),
      .rsp_minimum_value (rsp_minimum_value),
      .rsp_maximum_value (rsp_maximum_value),
      .rsp_count_overflow(rsp_count_overflow)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(negedge clock) begin
      rsp_pop = ($urandom_range(99) >= pop_stall_pct);
   end

   // monitor both channels and count cycles without progress
   always @(posedge clock) begin
      stats_word_type got;
      if (!reset) begin
         if (req_push && !req_full) sb.note_input(req_command, req_sample);
         if (rsp_pop && !rsp_empty) begin
            got.count = rsp_sample_count;
            got.mean = rsp_mean_value;
            got.variance = rsp_variance_value;
            got.minimum = rsp_minimum_value;
            got.maximum = rsp_maximum_value;
            got.overflow = rsp_count_overflow;
            sb.check_result(got);
         end
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= StallLimit) begin
               $display("%0t: watchdog expired", $time);
               $display("tb failed");
               $finish;
            end
         end
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic push_word(logic cmd, logic signed [rss_pkg::SamplePortBits-1:0] smp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push = 0;
         @(negedge clock);
      end
      req_push = 1;
      req_command = cmd;
      req_sample = smp;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (cmd == rss_pkg::CmdClear) clears_sent++;
      else samples_sent++;
   endtask

   function automatic logic signed [rss_pkg::SamplePortBits-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return 24'sh7FFFFF;
         1:       return -24'sh800000;
         2, 3:    return rss_pkg::SamplePortBits'($signed($urandom_range(200)) - 100);
         default: return rss_pkg::SamplePortBits'($urandom);
      endcase
   endfunction

   task automatic run_random(int n_items, int idle_pct, int stall_pct);
      send_idle_pct = idle_pct;
      pop_stall_pct = stall_pct;
      repeat (n_items) begin
         if ($urandom_range(99) == 0) begin
            push_word(rss_pkg::CmdClear, rss_pkg::SamplePortBits'($urandom));
         end else begin
            push_word(rss_pkg::CmdCollect, pick_sample());
         end
      end
   endtask

   task automatic hold_until_drained();
      req_push = 0;
      while (sb.expected_words.size() != 0) @(negedge clock);
   endtask

   initial begin
      sb.clear_stats();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, clear with a sample attached, single-sample stats
      push_word(rss_pkg::CmdCollect, 24'sh7FFFFF);
      push_word(rss_pkg::CmdCollect, -24'sh800000);
      push_word(rss_pkg::CmdCollect, 24'sh000000);
      push_word(rss_pkg::CmdCollect, -24'sh000001);
      push_word(rss_pkg::CmdCollect, 24'sh000001);
      push_word(rss_pkg::CmdClear, 24'sh5A5A5A);
      push_word(rss_pkg::CmdCollect, -24'sh000007);
      push_word(rss_pkg::CmdCollect, -24'sh000007);
      push_word(rss_pkg::CmdClear, '0);
      push_word(rss_pkg::CmdCollect, 24'sh7FFFFF);
      push_word(rss_pkg::CmdCollect, 24'sh7FFFFF);
      push_word(rss_pkg::CmdCollect, 24'sh7FFFFF);
      push_word(rss_pkg::CmdClear, '0);
      push_word(rss_pkg::CmdClear, '0);
      push_word(rss_pkg::CmdCollect, -24'sh800000);
      push_word(rss_pkg::CmdCollect, -24'sh800000);
      push_word(rss_pkg::CmdCollect, 24'sh7FFFFF);
      push_word(rss_pkg::CmdCollect, 24'sh123456);
      push_word(rss_pkg::CmdClear, '0);

      run_random(110, 0, 0);
      run_random(110, 59, 0);
      hold_until_drained();
      run_random(110, 0, 59);
      run_random(120, 20, 20);

      req_push = 0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d samples and %0d clears, %0d result words checked",
               samples_sent, clears_sent, sb.checked);
      $display("phases: no idling, sender idle, receiver stall, both, with a full drain");
      if (sb.errors == 0 && sb.expected_words.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
